// File: src/apfa_pkg.sv
// Shared word types, mode codes and controller states of the allele pair frequency accumulator.
package apfa_pkg;

  localparam int REG_GROUPS = 4;
  localparam int CFG_AW     = 6;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_ACCUM  = 3'd1,
    MODE_SINGLE = 3'd2,
    MODE_PAIR   = 3'd3,
    MODE_TRAIT  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] genotype;
    logic [23:0] weight;
    logic [6:0]  row_index;
    logic [6:0]  col_index;
  } item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        saturated;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CLEAR,
    S_ACC,
    S_FLUSH,
    S_READ,
    S_WAIT,
    S_DONE
  } state_t;

endpackage

// File: src/allele_pair_frequency_accumulator_core.sv
// Top level of the allele pair frequency accumulator: config registers, stores and sweep control.
//
// Usage. Items arrive on the item channel (item_valid / item_stall, payload item) and one
// result word per item leaves on the result channel (result_valid / result_stall, result).
// A word is taken at a clock edge with valid high and stall low.
// Group masks and wild-type patterns sit behind an APB-style port, 64-bit data, register i
// at byte address 8*i; write them only while the block is idle.
// Steps per item, set by the one read port and one write port of each store:
//   clear      : a sweep of SWEEP entries, one entry zeroed per cycle (SWEEP = 2278 by default,
//                the largest store depth).
//   accumulate : a sweep, then a flush; one pair entry per cycle is read and written back
//                through the s1 registers, singles and trait terms ride along in the
//                first cycles of the same sweep.
//   reads      : prepare, address, data, result.
//   other modes: prepare, result.
// Reset starts a clearing pass over all three stores; the item channel
// stalls during it, configuration writes are taken as ever.
// A stalled result holds in the output register; the next item is still taken and its
// result waits until the register frees.
module allele_pair_frequency_accumulator_core #(
  parameter int SITES     = 64,
  parameter int GROUPS    = 4,
  parameter int ACC_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  apfa_pkg::item_t          item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output apfa_pkg::result_t        result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [apfa_pkg::CFG_AW-1:0] paddr,
  input  logic [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);
  import apfa_pkg::*;

  localparam int ENTRIES = SITES + GROUPS;
  localparam int PDEPTH  = (ENTRIES * (ENTRIES - 1)) / 2;
  localparam int TDEPTH  = GROUPS * SITES;
  localparam int MAX_A   = (PDEPTH > ENTRIES) ? PDEPTH : ENTRIES;
  localparam int SWEEP   = (MAX_A > TDEPTH) ? MAX_A : TDEPTH;
  localparam int EW      = $clog2(ENTRIES);
  localparam int PW      = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int TW      = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int SW      = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int CW      = $clog2(SWEEP + 1);

  // ---------------- configuration registers ----------------
  logic [63:0] mask [REG_GROUPS];
  logic [63:0] wild [REG_GROUPS];
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < REG_GROUPS; g++) begin
        mask[g] <= '0;
        wild[g] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_idx[2]) wild[cfg_idx[1:0]] <= pwdata;
      else            mask[cfg_idx[1:0]] <= pwdata;
    end
  end

  always_comb begin
    if (cfg_idx[2]) prdata = wild[cfg_idx[1:0]];
    else            prdata = mask[cfg_idx[1:0]];
  end

  // ---------------- control state ----------------
  state_t          state, state_next;
  logic [CW-1:0]   cnt;
  logic [EW-1:0]   pa, pb;
  logic            clr_item;
  logic            sat_flag;
  item_t           cur;
  logic [ENTRIES-1:0] member;
  logic [GROUPS-1:0]  tone;
  logic [SW-1:0]      where [GROUPS];
  logic               rd_ok;
  logic [EW-1:0]      rd_s_addr;
  logic [PW-1:0]      rd_p_addr;
  logic [TW-1:0]      rd_t_addr;
  logic [31:0]        rv;

  logic sweep_last;
  assign sweep_last = (cnt == CW'(SWEEP - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (item_valid) state_next = S_PREP;
      S_PREP: begin
        unique case (cur.mode)
          MODE_CLEAR:                         state_next = S_CLEAR;
          MODE_ACCUM:                         state_next = S_ACC;
          MODE_SINGLE, MODE_PAIR, MODE_TRAIT: state_next = S_READ;
          default:                            state_next = S_DONE;
        endcase
      end
      S_CLEAR: if (sweep_last) state_next = clr_item ? S_DONE : S_IDLE;
      S_ACC:   if (sweep_last) state_next = S_FLUSH;
      S_FLUSH: state_next = S_DONE;
      S_READ:  state_next = S_WAIT;
      S_WAIT:  state_next = S_DONE;
      S_DONE:  if (!result_valid || !result_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign item_stall = (state != S_IDLE);

  // ---------------- stores ----------------
  logic [ACC_WIDTH-1:0] s_mem [ENTRIES];
  logic [ACC_WIDTH-1:0] p_mem [PDEPTH];
  logic [ACC_WIDTH-1:0] t_mem [TDEPTH];
  logic [ACC_WIDTH-1:0] s_rd, p_rd, t_rd, s_wd, p_wd, t_wd;
  logic [EW-1:0] s_ra, s_wa;
  logic [PW-1:0] p_ra, p_wa;
  logic [TW-1:0] t_ra, t_wa;
  logic          s_we, p_we, t_we;

  // first sweep stage: what the entry being read will need at write-back
  logic          s1_s_en, s1_p_en, s1_t_en;
  logic [EW-1:0] s1_s_a;
  logic [PW-1:0] s1_p_a;
  logic [TW-1:0] s1_t_a;
  logic          acc_s_en, acc_p_en, acc_t_en;
  logic [GW-1:0] tg;
  logic [TW-1:0] acc_t_a;

  always_comb begin
    tg       = cnt[GW-1:0];
    acc_s_en = (cnt < CW'(ENTRIES)) && member[cnt[EW-1:0]];
    acc_p_en = (cnt < CW'(PDEPTH)) && member[pa] && member[pb];
    acc_t_en = (cnt < CW'(GROUPS)) && tone[tg];
    acc_t_a  = TW'(32'(tg) * SITES + 32'(where[tg]));
  end

  // saturating adds at write-back
  logic [ACC_WIDTH:0] s_sum, p_sum, t_sum;
  logic               s_ov, p_ov, t_ov;
  always_comb begin
    s_sum = {1'b0, s_rd} + (ACC_WIDTH+1)'(cur.weight);
    p_sum = {1'b0, p_rd} + (ACC_WIDTH+1)'(cur.weight);
    t_sum = {1'b0, t_rd} + (ACC_WIDTH+1)'(cur.weight);
    s_ov  = s1_s_en && s_sum[ACC_WIDTH];
    p_ov  = s1_p_en && p_sum[ACC_WIDTH];
    t_ov  = s1_t_en && t_sum[ACC_WIDTH];
  end

  // store port control
  always_comb begin
    s_ra = (state == S_ACC) ? cnt[EW-1:0] : rd_s_addr;
    p_ra = (state == S_ACC) ? cnt[PW-1:0] : rd_p_addr;
    t_ra = (state == S_ACC) ? acc_t_a     : rd_t_addr;
    if (state == S_CLEAR) begin
      s_we = (cnt < CW'(ENTRIES));
      p_we = (cnt < CW'(PDEPTH));
      t_we = (cnt < CW'(TDEPTH));
      s_wa = cnt[EW-1:0];
      p_wa = cnt[PW-1:0];
      t_wa = cnt[TW-1:0];
      s_wd = '0;
      p_wd = '0;
      t_wd = '0;
    end else begin
      s_we = s1_s_en;
      p_we = s1_p_en;
      t_we = s1_t_en;
      s_wa = s1_s_a;
      p_wa = s1_p_a;
      t_wa = s1_t_a;
      s_wd = s_sum[ACC_WIDTH] ? '1 : s_sum[ACC_WIDTH-1:0];
      p_wd = p_sum[ACC_WIDTH] ? '1 : p_sum[ACC_WIDTH-1:0];
      t_wd = t_sum[ACC_WIDTH] ? '1 : t_sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[s_wa] <= s_wd;
    s_rd <= s_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    p_rd <= p_mem[p_ra];
  end

  always_ff @(posedge clk) begin
    if (t_we) t_mem[t_wa] <= t_wd;
    t_rd <= t_mem[t_ra];
  end

  // ---------------- item preparation ----------------
  logic [SITES-1:0]   geno_s;
  logic [SITES-1:0]   diff [GROUPS];
  logic [ENTRIES-1:0] member_next;
  logic [GROUPS-1:0]  tone_next;
  logic [SW-1:0]      where_next [GROUPS];
  logic [6:0]         lo, hi;
  logic [31:0]        tri_pos;
  logic               rd_ok_next;

  always_comb begin
    geno_s = cur.genotype[SITES-1:0];
    member_next[SITES-1:0] = geno_s;
    for (int g = 0; g < GROUPS; g++) begin
      diff[g] = (geno_s ^ wild[g][SITES-1:0]) & mask[g][SITES-1:0];
      member_next[SITES+g] = |diff[g];
      // exactly one differing site: non-zero with no second bit
      tone_next[g] = (|diff[g]) && ((diff[g] & (diff[g] - SITES'(1))) == '0);
      where_next[g] = '0;
      for (int i = 0; i < SITES; i++)
        if (diff[g][i]) where_next[g] = where_next[g] | SW'(i);
    end
    lo = (cur.row_index < cur.col_index) ? cur.row_index : cur.col_index;
    hi = (cur.row_index < cur.col_index) ? cur.col_index : cur.row_index;
    tri_pos = 32'(lo) * ENTRIES - ((32'(lo) * (32'(lo) + 32'd1)) >> 1)
              + 32'(hi) - 32'(lo) - 32'd1;
    case (cur.mode)
      MODE_SINGLE: rd_ok_next = (32'(cur.row_index) < ENTRIES);
      MODE_PAIR:   rd_ok_next = (32'(cur.row_index) < ENTRIES) &&
                                (32'(cur.col_index) < ENTRIES) &&
                                (cur.row_index != cur.col_index);
      MODE_TRAIT:  rd_ok_next = (32'(cur.row_index) < GROUPS) &&
                                (32'(cur.col_index) < SITES);
      default:     rd_ok_next = 1'b0;
    endcase
  end

  // ---------------- sequential control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      clr_item     <= 1'b0;
      sat_flag     <= 1'b0;
      result_valid <= 1'b0;
      s1_s_en      <= 1'b0;
      s1_p_en      <= 1'b0;
      s1_t_en      <= 1'b0;
    end else begin
      state <= state_next;

      // hold the item, release once done
      if (state == S_IDLE && item_valid) cur <= item;

      if (state == S_PREP) begin
        member    <= member_next;
        tone      <= tone_next;
        where     <= where_next;
        rd_ok     <= rd_ok_next;
        rd_s_addr <= cur.row_index[EW-1:0];
        rd_p_addr <= tri_pos[PW-1:0];
        rd_t_addr <= TW'(32'(cur.row_index) * SITES + 32'(cur.col_index));
        clr_item  <= 1'b1;
        cnt       <= '0;
        pa        <= '0;
        pb        <= EW'(1);
        if (cur.mode == MODE_CLEAR) sat_flag <= 1'b0;
      end

      if (state == S_CLEAR || state == S_ACC) begin
        cnt <= sweep_last ? '0 : cnt + CW'(1);
      end

      // advance the triangle walk
      if (state == S_ACC) begin
        if (pb == EW'(ENTRIES - 1)) begin
          pa <= pa + EW'(1);
          pb <= pa + EW'(2);
        end else begin
          pb <= pb + EW'(1);
        end
      end

      s1_s_en <= (state == S_ACC) && acc_s_en;
      s1_p_en <= (state == S_ACC) && acc_p_en;
      s1_t_en <= (state == S_ACC) && acc_t_en;
      s1_s_a  <= cnt[EW-1:0];
      s1_p_a  <= cnt[PW-1:0];
      s1_t_a  <= acc_t_a;

      if (s_ov || p_ov || t_ov) sat_flag <= 1'b1;

      if (state == S_PREP) rv <= '0;
      if (state == S_WAIT && rd_ok) begin
        case (cur.mode)
          MODE_SINGLE: rv <= 32'(s_rd);
          MODE_PAIR:   rv <= 32'(p_rd);
          default:     rv <= 32'(t_rd);
        endcase
      end

      // load a fresh word once the register frees, else drop a taken one
      if (state == S_DONE && (!result_valid || !result_stall)) begin
        result.read_value <= rv;
        result.saturated  <= sat_flag;
        result_valid      <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ---------------- checks ----------------
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(s_we || p_we || t_we))
    else $error("store written while idle");

  a_flush_after_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && sweep_last) |=> (state == S_FLUSH))
    else $error("accumulate sweep did not end in flush");

  a_writeback_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (s1_s_en || s1_p_en || s1_t_en) |-> (state == S_ACC || state == S_FLUSH))
    else $error("write-back outside accumulate sweep");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the allele pair frequency accumulator core.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the stores and queues the expected result words.
class freq_scoreboard;
  localparam int NSITE = 64;
  localparam int NGRP  = 4;
  localparam int NENT  = NSITE + NGRP;
  localparam logic [31:0] ACC_TOP = 32'hFFFF_FFFF;

  logic [63:0] mask_reg [4];
  logic [63:0] wild_reg [4];
  logic [31:0] single_acc [NENT];
  logic [31:0] pair_acc [NENT][NENT];
  logic [31:0] trait_acc [NGRP][NSITE];
  bit sat_flag;
  apfa_pkg::result_t expected_words[$];
  int fail_count;

  function new();
    for (int g = 0; g < 4; g++) begin
      mask_reg[g] = '0;
      wild_reg[g] = '0;
    end
    wipe_stores();
    fail_count = 0;
  endfunction

  function void wipe_stores();
    foreach (single_acc[i]) single_acc[i] = '0;
    foreach (pair_acc[i, j]) pair_acc[i][j] = '0;
    foreach (trait_acc[i, j]) trait_acc[i][j] = '0;
    sat_flag = 0;
  endfunction

  function logic [31:0] sat_sum(logic [31:0] acc, logic [23:0] w);
    logic [32:0] s;
    s = {1'b0, acc} + {9'd0, w};
    if (s[32]) begin
      sat_flag = 1;
      return ACC_TOP;
    end
    return s[31:0];
  endfunction

  function void add_genotype(logic [63:0] geno, logic [23:0] w);
    int members[$];
    logic [63:0] diff;
    int ndiff, where;
    for (int i = 0; i < NSITE; i++)
      if (geno[i]) members.push_back(i);
    for (int g = 0; g < NGRP; g++) begin
      diff = (geno ^ wild_reg[g]) & mask_reg[g];
      if (diff != 0) begin
        members.push_back(NSITE + g);
        ndiff = 0;
        where = 0;
        for (int i = 0; i < NSITE; i++)
          if (diff[i]) begin
            ndiff++;
            where = i;
          end
        if (ndiff == 1) trait_acc[g][where] = sat_sum(trait_acc[g][where], w);
      end
    end
    for (int i = 0; i < members.size(); i++) begin
      single_acc[members[i]] = sat_sum(single_acc[members[i]], w);
      for (int j = i + 1; j < members.size(); j++)
        pair_acc[members[i]][members[j]] = sat_sum(pair_acc[members[i]][members[j]], w);
    end
  endfunction

  // Note an accepted input word and queue the result it must produce.
  function void note_item(apfa_pkg::item_t it);
    apfa_pkg::result_t r;
    int a, b;
    r.read_value = '0;
    case (it.mode)
      apfa_pkg::MODE_CLEAR: wipe_stores();
      apfa_pkg::MODE_ACCUM: add_genotype(it.genotype, it.weight);
      apfa_pkg::MODE_SINGLE: if (it.row_index < NENT) r.read_value = single_acc[it.row_index];
      apfa_pkg::MODE_PAIR: begin
        if (it.row_index < NENT && it.col_index < NENT && it.row_index != it.col_index) begin
          a = (it.row_index < it.col_index) ? it.row_index : it.col_index;
          b = (it.row_index < it.col_index) ? it.col_index : it.row_index;
          r.read_value = pair_acc[a][b];
        end
      end
      apfa_pkg::MODE_TRAIT:
        if (it.row_index < NGRP && it.col_index < NSITE)
          r.read_value = trait_acc[it.row_index][it.col_index];
      default: ;
    endcase
    r.saturated = sat_flag;
    expected_words.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Check one result word against the oldest expectation.
  task check_result(apfa_pkg::result_t r);
    apfa_pkg::result_t e;
    if (expected_words.size() == 0) begin
      report("unexpected result word", {31'd0, r.saturated}, 32'd0);
      return;
    end
    e = expected_words.pop_front();
    if (r.read_value !== e.read_value) report("read_value", r.read_value, e.read_value);
    if (r.saturated !== e.saturated) report("saturated", {31'd0, r.saturated}, {31'd0, e.saturated});
  endtask
endclass

module tb_top;
  import apfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 2400;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 0;
  result_t result;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  freq_scoreboard board;
  bit sink_busy;      // hold result_stall low entirely during a stretch
  bit source_calm;    // no gaps from the sender during a stretch
  int quiet_cycles;

  always #5 clk = ~clk;

  allele_pair_frequency_accumulator_core uut (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial board = new();

  // Sample results at the rising edge; count idle cycles for the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_result(result);
      if ((result_valid && !result_stall) || (item_valid && !item_stall) || psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("** allele_pair_frequency_accumulator_core: FAILED **");
        $finish;
      end
    end else
      quiet_cycles <= 0;
  end

  // Receiver stalls at random, about 30 in a hundred, except in the calm stretch.
  always @(negedge clk)
    result_stall <= sink_busy ? 1'b0 : ($urandom_range(0, 99) < 30);

  task write_reg(int idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= CFG_AW'(8 * idx); pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx < 4) board.mask_reg[idx] = value;
    else board.wild_reg[idx - 4] = value;
  endtask

  // Drive one word, with an optional random gap first, and wait for its acceptance.
  task send_word(item_t it);
    @(negedge clk);
    if (!source_calm)
      while ($urandom_range(0, 99) < 30) @(negedge clk);
    item_valid <= 1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    board.note_item(it);
    @(negedge clk);
    item_valid <= 0;
  endtask

  task drain();
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function item_t make_word(mode_t m, logic [63:0] g, logic [23:0] w, int r, int c);
    item_t it;
    it.mode = m; it.genotype = g; it.weight = w;
    it.row_index = 7'(r); it.col_index = 7'(c);
    return it;
  endfunction

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // A random item; accumulates lean on sparse genotypes so pair reads hit live entries.
  function item_t random_word();
    item_t it;
    logic [127:0] raw;
    int pick;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.mode = MODE_ACCUM;
      if ($urandom_range(0, 1)) it.genotype = rand64() & rand64() & rand64();
      if ($urandom_range(0, 3) == 0) it.weight = 24'(24'hFFFFFF - $urandom_range(0, 15));
    end else if (pick < 58) it.mode = MODE_SINGLE;
    else if (pick < 76) it.mode = MODE_PAIR;
    else if (pick < 92) it.mode = MODE_TRAIT;
    else if (pick < 95) it.mode = MODE_CLEAR;
    else it.mode = mode_t'(3'($urandom_range(5, 7)));
    if (it.mode != MODE_ACCUM && $urandom_range(0, 4) != 0) begin
      it.row_index = (it.mode == MODE_TRAIT) ? 7'($urandom_range(0, 3))
                                             : 7'($urandom_range(0, 67));
      it.col_index = (it.mode == MODE_TRAIT) ? 7'($urandom_range(0, 63))
                                             : 7'($urandom_range(0, 67));
    end
    return it;
  endfunction

  initial begin
    sink_busy = 0;
    source_calm = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: single-site trait groups, extremes, every mode and the open cases.
    write_reg(0, 64'h0000_0000_0000_0001);
    write_reg(1, 64'h8000_0000_0000_0000);
    write_reg(2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(3, 64'h0000_0000_0000_0000);
    write_reg(4, 64'h0);
    write_reg(5, 64'h8000_0000_0000_0000);
    write_reg(6, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(make_word(MODE_ACCUM, 64'h1, 24'hFFFFFF, 0, 0));
    send_word(make_word(MODE_ACCUM, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 127, 127));
    send_word(make_word(MODE_ACCUM, 64'h0, 24'h123456, 0, 0));
    send_word(make_word(MODE_ACCUM, 64'h8000_0000_0000_0001, 24'h0, 0, 0));
    send_word(make_word(MODE_SINGLE, '0, '0, 0, 0));
    send_word(make_word(MODE_SINGLE, '0, '0, 66, 0));
    send_word(make_word(MODE_SINGLE, '0, '0, 127, 0));
    send_word(make_word(MODE_PAIR, '0, '0, 0, 63));
    send_word(make_word(MODE_PAIR, '0, '0, 63, 0));
    send_word(make_word(MODE_PAIR, '0, '0, 5, 5));
    send_word(make_word(MODE_PAIR, '0, '0, 64, 67));
    send_word(make_word(MODE_PAIR, '0, '0, 68, 2));
    send_word(make_word(MODE_TRAIT, '0, '0, 2, 0));
    send_word(make_word(MODE_TRAIT, '0, '0, 0, 0));
    send_word(make_word(MODE_TRAIT, '0, '0, 4, 0));
    send_word(make_word(MODE_TRAIT, '0, '0, 1, 64));
    send_word(make_word(mode_t'(3'd7), '1, '1, 127, 127));
    send_word(make_word(mode_t'(3'd5), '0, '0, 0, 0));
    // Accumulate one heavy-weight item on site 1.
    for (int k = 0; k < 260; k++)
      if (k == 0) send_word(make_word(MODE_ACCUM, 64'h2, 24'hFFFFFF, 0, 0));
    send_word(make_word(MODE_CLEAR, '0, '0, 0, 0));
    send_word(make_word(MODE_SINGLE, '0, '0, 1, 0));

    // Random phases, each under fresh group settings; wait for idle before writing.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      for (int r = 0; r < 8; r++)
        write_reg(r, (phase == 3) ? 64'h0 : rand64() & (phase == 0 ? 64'h0000_0000_0000_00FF : '1));
      source_calm = (phase == 1);
      sink_busy = (phase == 1);
      for (int k = 0; k < 60; k++) send_word(random_word());
      source_calm = 0;
      sink_busy = 0;
    end
    // Add one heavy weight to the pair of sites 0 and 1, then read it back twice.
    for (int k = 0; k < 260; k++) begin
      if (k < 258) begin
        if (k == 0) send_word(make_word(MODE_ACCUM, 64'h3, 24'hFFFFFF, 0, 0));
      end
    end
    for (int k = 0; k < 2; k++) send_word(make_word(MODE_PAIR, '0, '0, 0, 1));
    drain();
    if (board.fail_count == 0 && board.expected_words.size() == 0)
      $display("** allele_pair_frequency_accumulator_core: PASSED **");
    else
      $display("** allele_pair_frequency_accumulator_core: FAILED **");
    $finish;
  end
endmodule
